// ===== sv/assert_macros.svh =====
// assertion macros shared by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// property checked outside reset
`define ASSERT_CLKRST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== sv/lmfs_pkg.sv =====
// shared types and constants of the led matrix frame serializer
`default_nettype none

package lmfs_pkg;

   localparam int ROW_COUNT   = 16;
   localparam int ROW_AW      = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
   localparam int WORD_W      = 16;
   localparam int FRAME_LEN   = ROW_COUNT + 3;
   localparam int REFRESH_LEN = 2 * FRAME_LEN;
   localparam int BLANK_LEN   = ROW_COUNT + 6;
   localparam int SEND_LEN    = 3;
   localparam int POS_W       = $clog2(REFRESH_LEN + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] START_ADDR_RESET = 8'hC0;
   localparam logic [7:0] AUTO_INC_RESET   = 8'h40;

   localparam logic CSR_START_ADDR = 1'b0;
   localparam logic CSR_AUTO_INC   = 1'b1;

   typedef enum logic [2:0] {
      CMD_SET_PIXEL     = 3'd0,
      CMD_CLEAR_PIXEL   = 3'd1,
      CMD_CLEAR_STORE   = 3'd2,
      CMD_REFRESH       = 3'd3,
      CMD_CLEAR_DISPLAY = 3'd4,
      CMD_SEND_COMMAND  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_DATA  = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   typedef struct packed {
      cmd_type    op;
      logic [3:0] column;
      logic [3:0] bit_index;
      logic       link;
      logic [7:0] command_byte;
   } entry_type;

   typedef struct packed {
      logic [7:0] start_address;
      logic [7:0] auto_increment;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

// ===== sv/lmfs_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module lmfs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/lmfs_front.sv =====
// command intake: handshake, filtering and configuration registers
`default_nettype none

module lmfs_front import lmfs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_command,
   input  logic [3:0] req_column,
   input  logic [3:0] req_bit_index,
   input  logic       req_display_sel,
   input  logic [7:0] req_command_byte,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   input  qstat_type  qstat,
   output logic       push,
   output entry_type  push_entry,
   output cfg_type    cfg
);

   logic       accept;
   logic       keep;
   logic [7:0] start_addr_ff;
   logic [7:0] start_addr_in;
   logic [7:0] auto_inc_ff;
   logic [7:0] auto_inc_in;

   assign busy   = qstat.full;
   assign accept = start && !qstat.full;

   always_comb begin
      case (req_command)
         CMD_SET_PIXEL, CMD_CLEAR_PIXEL: begin
            keep = ({1'b0, req_column} < 5'(ROW_COUNT));
         end
         CMD_CLEAR_STORE, CMD_REFRESH, CMD_CLEAR_DISPLAY, CMD_SEND_COMMAND: begin
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push                    = accept && keep;
   assign push_entry.op           = cmd_type'(req_command);
   assign push_entry.column       = req_column;
   assign push_entry.bit_index    = req_bit_index;
   assign push_entry.link         = req_display_sel;
   assign push_entry.command_byte = req_command_byte;

   assign csr_ready = 1'b1;

   always_comb begin
      start_addr_in = start_addr_ff;
      auto_inc_in   = auto_inc_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_START_ADDR: begin
               start_addr_in = csr_wdata;
            end
            CSR_AUTO_INC: begin
               auto_inc_in = csr_wdata;
            end
            default: begin
               start_addr_in = start_addr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_addr_ff <= START_ADDR_RESET;
         auto_inc_ff   <= AUTO_INC_RESET;
      end else begin
         start_addr_ff <= start_addr_in;
         auto_inc_ff   <= auto_inc_in;
      end
   end

   assign cfg.start_address  = start_addr_ff;
   assign cfg.auto_increment = auto_inc_ff;

endmodule

`default_nettype wire

// ===== sv/lmfs_queue.sv =====
// short command queue between intake and sequencer
`default_nettype none

module lmfs_queue import lmfs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output qstat_type qstat
);

   entry_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              do_push;
   logic              do_pop;

   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== sv/lmfs_back.sv =====
// sequencer: pixel store updates and frame symbol generation
`default_nettype none

module lmfs_back import lmfs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  qstat_type  qstat,
   input  entry_type  head,
   output logic       pop,
   input  cfg_type    cfg,
   output logic       rsp_valid,
   output logic       rsp_link,
   output logic [1:0] rsp_symbol_kind,
   output logic [7:0] rsp_byte_value,
   output logic       rsp_last
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_MODIFY = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   state_type            state_ff;
   state_type            state_in;
   entry_type            cur_ff;
   entry_type            cur_in;
   logic [POS_W-1:0]     pos_ff;
   logic [POS_W-1:0]     pos_in;
   logic [ROW_COUNT-1:0] row_valid_ff;
   logic [ROW_COUNT-1:0] row_valid_in;
   logic                 rd_valid_ff;
   logic [ROW_AW-1:0]    rd_addr;
   logic [WORD_W-1:0]    rd_data;
   logic [WORD_W-1:0]    word;
   logic [WORD_W-1:0]    mask;
   logic                 wr_en;
   logic [WORD_W-1:0]    wr_data;
   logic [POS_W-1:0]     frame_pos;
   logic                 sym_link;
   kind_type             sym_kind;
   logic [7:0]           sym_byte;
   logic                 sym_last;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 rsp_link_ff;
   kind_type             rsp_kind_ff;
   logic [7:0]           rsp_byte_ff;
   logic                 rsp_last_ff;

   function automatic logic [ROW_AW-1:0] row_of(input logic [POS_W-1:0] pos);
      logic [POS_W-1:0] r;
      if (pos < POS_W'(FRAME_LEN)) begin
         r = pos - POS_W'(2);
         return r[ROW_AW-1:0];
      end
      r = pos - POS_W'(FRAME_LEN + 2);
      return ROW_AW'(ROW_COUNT - 1) - r[ROW_AW-1:0];
   endfunction

   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7 - i];
      end
      return r;
   endfunction

   lmfs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ROW_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cur_ff.column[ROW_AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign word    = rd_valid_ff ? rd_data : '0;
   assign mask    = WORD_W'(1) << cur_ff.bit_index;
   assign wr_data = (cur_ff.op == CMD_SET_PIXEL) ? (word | mask) : (word & ~mask);

   // symbol for the current position of the active frame sequence
   always_comb begin
      sym_link  = cur_ff.link;
      sym_kind  = KIND_END;
      sym_byte  = '0;
      sym_last  = 1'b0;
      frame_pos = pos_ff;
      case (cur_ff.op)
         CMD_REFRESH: begin
            if (pos_ff < POS_W'(FRAME_LEN)) begin
               sym_link  = 1'b0;
               frame_pos = pos_ff;
            end else begin
               sym_link  = 1'b1;
               frame_pos = pos_ff - POS_W'(FRAME_LEN);
            end
            if (frame_pos == POS_W'(0)) begin
               sym_kind = KIND_START;
            end else if (frame_pos == POS_W'(1)) begin
               sym_kind = KIND_DATA;
               sym_byte = cfg.start_address;
            end else if (frame_pos == POS_W'(FRAME_LEN - 1)) begin
               sym_kind = KIND_END;
            end else begin
               sym_kind = KIND_DATA;
               sym_byte = sym_link ? rev8(word[15:8]) : word[7:0];
            end
            sym_last = (pos_ff == POS_W'(REFRESH_LEN - 1));
         end
         CMD_CLEAR_DISPLAY: begin
            if (pos_ff == POS_W'(0) || pos_ff == POS_W'(3)) begin
               sym_kind = KIND_START;
            end else if (pos_ff == POS_W'(1)) begin
               sym_kind = KIND_DATA;
               sym_byte = cfg.auto_increment;
            end else if (pos_ff == POS_W'(4)) begin
               sym_kind = KIND_DATA;
               sym_byte = cfg.start_address;
            end else if (pos_ff == POS_W'(2) || pos_ff == POS_W'(BLANK_LEN - 1)) begin
               sym_kind = KIND_END;
            end else begin
               sym_kind = KIND_DATA;
            end
            sym_last = (pos_ff == POS_W'(BLANK_LEN - 1));
         end
         default: begin
            if (pos_ff == POS_W'(0)) begin
               sym_kind = KIND_START;
            end else if (pos_ff == POS_W'(1)) begin
               sym_kind = KIND_DATA;
               sym_byte = cur_ff.command_byte;
            end else begin
               sym_kind = KIND_END;
            end
            sym_last = (pos_ff == POS_W'(SEND_LEN - 1));
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      row_valid_in = row_valid_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      rsp_valid_in = 1'b0;
      rd_addr      = row_of(pos_ff + POS_W'(1));
      case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop     = 1'b1;
               cur_in  = head;
               pos_in  = '0;
               rd_addr = head.column[ROW_AW-1:0];
               case (head.op)
                  CMD_SET_PIXEL, CMD_CLEAR_PIXEL: begin
                     state_in = ST_MODIFY;
                  end
                  CMD_CLEAR_STORE: begin
                     row_valid_in = '0;
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_MODIFY: begin
            wr_en = 1'b1;
            row_valid_in[cur_ff.column[ROW_AW-1:0]] = 1'b1;
            state_in = ST_IDLE;
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            pos_in       = pos_ff + POS_W'(1);
            if (sym_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      pos_ff      <= pos_in;
      rd_valid_ff <= row_valid_ff[rd_addr];
      rsp_link_ff <= sym_link;
      rsp_kind_ff <= sym_kind;
      rsp_byte_ff <= sym_byte;
      rsp_last_ff <= sym_last;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_link        = rsp_link_ff;
   assign rsp_symbol_kind = rsp_kind_ff;
   assign rsp_byte_value  = rsp_byte_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

// ===== sv/led_matrix_frame_serializer_top.sv =====
// top level of the led matrix frame serializer
//
// A command is taken when start is high and busy is low; a two-entry queue
// holds commands until the sequencer gets to them, and busy is high only
// while that queue is full. The sequencer handles one command at a time,
// taking each command from the queue in its idle state:
// - set or clear pixel reads then writes the row ram
// - clear store clears the per-row valid bits and emits no symbols
// - send command emits 3 symbols
// - clear display emits 22 symbols
// - refresh emits 38 symbols
// Symbols leave one per clock on the rsp_ ports. Each is marked by rsp_valid
// for exactly one cycle, with no way to hold it off. From an idle sequencer,
// a command passes the queue, the sequencer state and the output registers
// before its first symbol is on the ports. Refresh data comes from the
// single read port of the row ram. The pixel store is cleared at reset
// through per-row valid bits, so no clearing pass is needed.
`default_nettype none

module led_matrix_frame_serializer_top import lmfs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_command,
   input  logic [3:0] req_column,
   input  logic [3:0] req_bit_index,
   input  logic       req_display_sel,
   input  logic [7:0] req_command_byte,
   output logic       rsp_valid,
   output logic       rsp_link,
   output logic [1:0] rsp_symbol_kind,
   output logic [7:0] rsp_byte_value,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   qstat_type qstat;
   logic      push;
   entry_type push_entry;
   logic      pop;
   entry_type head;
   cfg_type   cfg;

   lmfs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_column       (req_column),
      .req_bit_index    (req_bit_index),
      .req_display_sel  (req_display_sel),
      .req_command_byte (req_command_byte),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .qstat            (qstat),
      .push             (push),
      .push_entry       (push_entry),
      .cfg              (cfg)
   );

   lmfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   lmfs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .qstat           (qstat),
      .head            (head),
      .pop             (pop),
      .cfg             (cfg),
      .rsp_valid       (rsp_valid),
      .rsp_link        (rsp_link),
      .rsp_symbol_kind (rsp_symbol_kind),
      .rsp_byte_value  (rsp_byte_value),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// ===== sv/lmfs_checker.sv =====
// port level checks of the frame serializer, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module lmfs_checker import lmfs_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic [1:0] rsp_symbol_kind,
   input logic [7:0] rsp_byte_value,
   input logic       rsp_last
);

   logic start_sym;
   logic byte_sym;
   logic last_sym;
   logic end_kind;
   logic zero_byte;

   assign start_sym = rsp_valid && (rsp_symbol_kind == KIND_START);
   assign byte_sym  = rsp_valid && (rsp_symbol_kind == KIND_DATA);
   assign last_sym  = rsp_valid && rsp_last;
   assign end_kind  = (rsp_symbol_kind == KIND_END);
   assign zero_byte = (rsp_byte_value == 8'd0);

   `ASSERT_ALWAYS(a_quiet_after_reset, clock, reset |=> !rsp_valid, "item after reset")
   `ASSERT_CLKRST(a_start_zero, clock, reset, start_sym |-> zero_byte, "start byte nonzero")
   `ASSERT_CLKRST(a_last_is_end, clock, reset, last_sym |-> end_kind, "last item not an end")
   `ASSERT_CLKRST(a_start_then_byte, clock, reset, start_sym |=> byte_sym, "no byte after start")

endmodule

bind led_matrix_frame_serializer_top lmfs_checker u_checker (.*);

`default_nettype wire

// ===== test/led_matrix_frame_serializer_top_tb.sv =====
// self-checking testbench for the led matrix frame serializer top level
`default_nettype none

module led_matrix_frame_serializer_top_tb;
   import lmfs_pkg::*;

   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;
   localparam int SETTLE_CYCLES = 48;
   localparam int PHASE_ITEMS = 18;
   localparam int NOT_TYPED = -1;

   typedef struct packed {
      logic [2:0] op;
      logic [3:0] column;
      logic [3:0] bit_index;
      logic       sel;
      logic [7:0] cbyte;
   } cmd_item_type;

   typedef struct packed {
      cmd_item_type item;
      int           typed_count;
      logic [7:0]   typed_head;
   } stim_row_type;

   typedef struct packed {
      logic       link;
      logic [1:0] kind;
      logic [7:0] value;
      logic       last;
   } symbol_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [2:0] req_command;
   logic [3:0] req_column;
   logic [3:0] req_bit_index;
   logic       req_display_sel;
   logic [7:0] req_command_byte;
   logic       rsp_valid;
   logic       rsp_link;
   logic [1:0] rsp_symbol_kind;
   logic [7:0] rsp_byte_value;
   logic       rsp_last;
   logic       csr_valid;
   logic       csr_ready;
   logic       csr_index;
   logic [7:0] csr_wdata;

   symbol_type  symbols_expected[$];
   logic [15:0] pixel_rows[ROW_COUNT];
   logic [7:0]  addr_byte_cfg;
   logic [7:0]  auto_inc_cfg;
   int          errors;
   bit          no_gaps;

   led_matrix_frame_serializer_top u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_column       (req_column),
      .req_bit_index    (req_bit_index),
      .req_display_sel  (req_display_sel),
      .req_command_byte (req_command_byte),
      .rsp_valid        (rsp_valid),
      .rsp_link         (rsp_link),
      .rsp_symbol_kind  (rsp_symbol_kind),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #400000;
      $display("** led_matrix_frame_serializer_top: FAILED **");
      $finish;
   end

   function automatic void push_symbol(logic link, kind_type kind, logic [7:0] value);
      symbol_type s;
      s.link  = link;
      s.kind  = kind;
      s.value = value;
      s.last  = 1'b0;
      symbols_expected.push_back(s);
   endfunction

   function automatic void push_command_frame(logic link, logic [7:0] value);
      push_symbol(link, KIND_START, 8'h00);
      push_symbol(link, KIND_DATA, value);
      push_symbol(link, KIND_END, 8'h00);
   endfunction

   // returns the number of frame symbols the command produces
   function automatic int predict_symbols(cmd_item_type c);
      int         n0;
      logic [7:0] hi;
      logic [7:0] rev;
      n0 = symbols_expected.size();
      case (c.op)
         CMD_SET_PIXEL: begin
            if (c.column < ROW_COUNT) pixel_rows[c.column][c.bit_index] = 1'b1;
         end
         CMD_CLEAR_PIXEL: begin
            if (c.column < ROW_COUNT) pixel_rows[c.column][c.bit_index] = 1'b0;
         end
         CMD_CLEAR_STORE: begin
            for (int r = 0; r < ROW_COUNT; r++) pixel_rows[r] = '0;
         end
         CMD_REFRESH: begin
            for (int lk = 0; lk < 2; lk++) begin
               push_symbol(lk[0], KIND_START, 8'h00);
               push_symbol(lk[0], KIND_DATA, addr_byte_cfg);
               for (int r = 0; r < ROW_COUNT; r++) begin
                  if (lk == 0) begin
                     push_symbol(1'b0, KIND_DATA, pixel_rows[r][7:0]);
                  end else begin
                     // link 1 runs rows backward with each high byte mirrored
                     hi = pixel_rows[ROW_COUNT - 1 - r][15:8];
                     for (int b = 0; b < 8; b++) rev[b] = hi[7 - b];
                     push_symbol(1'b1, KIND_DATA, rev);
                  end
               end
               push_symbol(lk[0], KIND_END, 8'h00);
            end
         end
         CMD_CLEAR_DISPLAY: begin
            push_command_frame(c.sel, auto_inc_cfg);
            push_symbol(c.sel, KIND_START, 8'h00);
            push_symbol(c.sel, KIND_DATA, addr_byte_cfg);
            for (int r = 0; r < ROW_COUNT; r++) push_symbol(c.sel, KIND_DATA, 8'h00);
            push_symbol(c.sel, KIND_END, 8'h00);
         end
         CMD_SEND_COMMAND: begin
            push_command_frame(c.sel, c.cbyte);
         end
         default: begin
         end
      endcase
      if (symbols_expected.size() > n0) begin
         symbols_expected[symbols_expected.size() - 1].last = 1'b1;
      end
      return symbols_expected.size() - n0;
   endfunction

   function automatic cmd_item_type random_item();
      cmd_item_type c;
      int           p;
      p           = $urandom_range(99);
      c.column    = 4'($urandom_range(15));
      c.bit_index = 4'($urandom_range(15));
      c.sel       = 1'($urandom_range(1));
      c.cbyte     = 8'($urandom_range(255));
      if (p < 34)      c.op = CMD_SET_PIXEL;
      else if (p < 52) c.op = CMD_CLEAR_PIXEL;
      else if (p < 66) c.op = CMD_REFRESH;
      else if (p < 74) c.op = CMD_CLEAR_DISPLAY;
      else if (p < 86) c.op = CMD_SEND_COMMAND;
      else if (p < 90) c.op = CMD_CLEAR_STORE;
      else             c.op = ($urandom_range(1) != 0) ? CMD_SPARE_7 : CMD_SPARE_6;
      return c;
   endfunction

   task automatic send_item(input cmd_item_type c, output int produced);
      start            <= 1'b1;
      req_command      <= c.op;
      req_column       <= c.column;
      req_bit_index    <= c.bit_index;
      req_display_sel  <= c.sel;
      req_command_byte <= c.cbyte;
      @(posedge clock);
      while (busy) @(posedge clock);
      produced = predict_symbols(c);
   endtask

   task automatic idle_maybe();
      if (!no_gaps && $urandom_range(99) < 8) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // wait until every frame symbol is in, then let queued pixel commands finish
   task automatic settle();
      start <= 1'b0;
      while (symbols_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic [7:0] start_addr, logic [7:0] auto_inc);
      csr_valid <= 1'b1;
      csr_index <= CSR_START_ADDR;
      csr_wdata <= start_addr;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      addr_byte_cfg = start_addr;
      csr_index <= CSR_AUTO_INC;
      csr_wdata <= auto_inc;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      auto_inc_cfg = auto_inc;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      symbol_type want;
      if (!reset && rsp_valid) begin
         if (symbols_expected.size() == 0) begin
            $error("unexpected symbol: link %0d kind %0d byte %02h last %0d",
                   rsp_link, rsp_symbol_kind, rsp_byte_value, rsp_last);
            errors++;
         end else begin
            want = symbols_expected.pop_front();
            if (rsp_link !== want.link) begin
               $error("link: expected %0d, got %0d", want.link, rsp_link);
               errors++;
            end
            if (rsp_symbol_kind !== want.kind) begin
               $error("symbol_kind: expected %0d, got %0d", want.kind, rsp_symbol_kind);
               errors++;
            end
            if (rsp_byte_value !== want.value) begin
               $error("byte_value: expected %02h, got %02h", want.value, rsp_byte_value);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   initial begin
      stim_row_type directed[20];
      logic [15:0]  phase_cfg[5];
      int           produced;
      int           taken;
      cmd_item_type c;

      directed = '{
         '{'{CMD_REFRESH,       4'd0,  4'd0,  1'b0, 8'h00}, 38,        8'hC0},
         '{'{CMD_SEND_COMMAND,  4'd0,  4'd0,  1'b0, 8'h00}, 3,         8'h00},
         '{'{CMD_SEND_COMMAND,  4'd15, 4'd15, 1'b1, 8'hFF}, 3,         8'hFF},
         '{'{CMD_CLEAR_DISPLAY, 4'd0,  4'd0,  1'b0, 8'h00}, 22,        8'h40},
         '{'{CMD_CLEAR_DISPLAY, 4'd15, 4'd15, 1'b1, 8'hFF}, 22,        8'h40},
         '{'{CMD_SPARE_6,       4'd3,  4'd3,  1'b0, 8'h5A}, 0,         8'h00},
         '{'{CMD_SPARE_7,       4'd12, 4'd12, 1'b1, 8'hA5}, 0,         8'h00},
         '{'{CMD_SET_PIXEL,     4'd0,  4'd0,  1'b0, 8'h00}, 0,         8'h00},
         '{'{CMD_SET_PIXEL,     4'd15, 4'd15, 1'b1, 8'hFF}, 0,         8'h00},
         '{'{CMD_SET_PIXEL,     4'd0,  4'd15, 1'b0, 8'h00}, 0,         8'h00},
         '{'{CMD_SET_PIXEL,     4'd15, 4'd0,  1'b0, 8'h00}, 0,         8'h00},
         '{'{CMD_SET_PIXEL,     4'd7,  4'd8,  1'b1, 8'h00}, 0,         8'h00},
         '{'{CMD_SET_PIXEL,     4'd8,  4'd7,  1'b0, 8'h00}, 0,         8'h00},
         '{'{CMD_REFRESH,       4'd0,  4'd0,  1'b1, 8'h00}, NOT_TYPED, 8'h00},
         '{'{CMD_CLEAR_PIXEL,   4'd0,  4'd0,  1'b0, 8'h00}, 0,         8'h00},
         '{'{CMD_CLEAR_PIXEL,   4'd15, 4'd15, 1'b1, 8'hFF}, 0,         8'h00},
         '{'{CMD_CLEAR_PIXEL,   4'd7,  4'd8,  1'b0, 8'h00}, 0,         8'h00},
         '{'{CMD_REFRESH,       4'd0,  4'd0,  1'b0, 8'h00}, NOT_TYPED, 8'h00},
         '{'{CMD_CLEAR_STORE,   4'd0,  4'd0,  1'b0, 8'h00}, 0,         8'h00},
         '{'{CMD_REFRESH,       4'd15, 4'd15, 1'b1, 8'hFF}, 38,        8'hC0}
      };
      phase_cfg = '{
         {8'h00, 8'hFF},
         {8'hFF, 8'h00},
         {8'($urandom_range(255)), 8'($urandom_range(255))},
         {START_ADDR_RESET, AUTO_INC_RESET},
         {8'($urandom_range(255)), 8'($urandom_range(255))}
      };

      errors           = 0;
      no_gaps          = 1'b0;
      addr_byte_cfg    = START_ADDR_RESET;
      auto_inc_cfg     = AUTO_INC_RESET;
      for (int r = 0; r < ROW_COUNT; r++) pixel_rows[r] = '0;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_command      <= CMD_SET_PIXEL;
      req_column       <= '0;
      req_bit_index    <= '0;
      req_display_sel  <= 1'b0;
      req_command_byte <= '0;
      csr_valid        <= 1'b0;
      csr_index        <= CSR_START_ADDR;
      csr_wdata        <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         send_item(directed[i].item, produced);
         if (directed[i].typed_count != NOT_TYPED) begin
            if (produced != directed[i].typed_count) begin
               $error("symbol count: expected %0d, got %0d",
                      directed[i].typed_count, produced);
               errors++;
            end else if (produced > 1 &&
                         symbols_expected[symbols_expected.size() - produced + 1].value
                         !== directed[i].typed_head) begin
               $error("frame head byte: expected %02h, got %02h", directed[i].typed_head,
                      symbols_expected[symbols_expected.size() - produced + 1].value);
               errors++;
            end
         end
         idle_maybe();
      end

      foreach (phase_cfg[p]) begin
         settle();
         configure(phase_cfg[p][15:8], phase_cfg[p][7:0]);
         no_gaps = (p == 2);
         taken   = 0;
         while (taken < PHASE_ITEMS) begin
            c = random_item();
            send_item(c, produced);
            taken++;
            idle_maybe();
         end
      end

      settle();
      if (errors == 0) begin
         $display("** led_matrix_frame_serializer_top: PASSED **");
      end else begin
         $display("** led_matrix_frame_serializer_top: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
